/* hdl/ilid_pkg.sv */
// ----------------------------------------------------------------------------
// ilid_pkg: shared types and codes for the indexed list
// Request and response item layouts, request kinds, status codes and the
// command broadcast to every entry cell.
// ----------------------------------------------------------------------------
package ilid_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 7;
    localparam int KIND_W = 3;
    localparam int STAT_W = 2;

    localparam logic [KIND_W-1:0] KIND_READ      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INS_FRONT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_APPEND    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INS_AT    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DELETE    = 3'd4;

    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [STAT_W-1:0]        status;
        logic [POS_W-1:0]         length;
    } rsp_t;

    typedef struct packed {
        logic              ins;
        logic              del;
        logic              rd;
        logic [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

/* hdl/ilid_cell.sv */
// ----------------------------------------------------------------------------
// ilid_cell: one entry of the list
// Holds one value and, on an insert or delete, takes its left or right
// neighbour's value or the new value, according to its own index.
// ----------------------------------------------------------------------------
module ilid_cell #(
    parameter int PW  = 7,
    parameter int IDX = 0
) (
    input  logic                           clk,
    input  ilid_pkg::cell_cmd_t            cmd,
    input  logic [PW-1:0]                  pos,
    input  logic [ilid_pkg::DATA_W-1:0]    left,
    input  logic [ilid_pkg::DATA_W-1:0]    right,
    output logic [ilid_pkg::DATA_W-1:0]    data,
    output logic [ilid_pkg::DATA_W-1:0]    rd_data
);
    import ilid_pkg::*;

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins)
        begin
            if (MY_IDX > pos)
            begin
                data_next = left;
            end
            else if (MY_IDX == pos)
            begin
                data_next = cmd.value;
            end
        end
        else if (cmd.del)
        begin
            if (MY_IDX >= pos)
            begin
                data_next = right;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = (cmd.rd && (pos == MY_IDX)) ? data_reg : '0;

endmodule

/* hdl/indexed_list_insert_delete.sv */
// ----------------------------------------------------------------------------
// indexed_list_insert_delete: bounded positional list of signed values
// A row of CAPACITY entry cells shifts right on an insert and left on a
// delete; reads select one cell by position. One response per request.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_stall   req   (kind, position, value)
//   rsp      out        rsp_valid/rsp_stall   rsp   (read_value, status, length)
//
// All cells update in parallel at the edge that accepts a request, and the
// response is registered for the next cycle.
// A new request is taken every cycle unless a response waits under stall.
// Reset clears the entry count and the response valid; entry contents are
// not reset and need no clearing pass.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete #(
    parameter int CAPACITY = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  ilid_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output ilid_pkg::rsp_t rsp
);
    import ilid_pkg::*;

    localparam int PW   = $clog2(CAPACITY + 1);
    localparam int WW   = (PW > POS_W) ? PW : POS_W;
    localparam int RD_N = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);

    logic [PW-1:0]     count_reg;
    logic [PW-1:0]     count_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;

    logic              fire;
    logic              full;
    logic [WW-1:0]     pos_w;
    logic [WW-1:0]     cnt_w;
    logic [WW-1:0]     eff_pos;
    logic              do_ins;
    logic              do_del;
    logic              do_rd;
    logic [STAT_W-1:0] status;
    cell_cmd_t         cmd;
    logic [PW-1:0]     cell_pos;
    logic [DATA_W-1:0] rd_or;

    logic [DATA_W-1:0] cell_data [CAPACITY];
    logic [DATA_W-1:0] cell_rd   [CAPACITY];

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign fire      = req_valid && !req_stall;
    assign full      = (count_reg == PW'(CAPACITY));
    assign pos_w     = WW'(req.position);
    assign cnt_w     = WW'(count_reg);

    always_comb
    begin
        do_ins  = 1'b0;
        do_del  = 1'b0;
        do_rd   = 1'b0;
        eff_pos = pos_w;
        status  = ST_INVALID;
        case (req.kind)
            KIND_READ:
            begin
                if (pos_w < cnt_w)
                begin
                    do_rd  = 1'b1;
                    status = ST_DONE;
                end
            end
            KIND_INS_FRONT:
            begin
                eff_pos = '0;
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    do_ins = 1'b1;
                    status = ST_DONE;
                end
            end
            KIND_APPEND:
            begin
                eff_pos = cnt_w;
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    do_ins = 1'b1;
                    status = ST_DONE;
                end
            end
            KIND_INS_AT:
            begin
                if (pos_w > cnt_w)
                begin
                    status = ST_INVALID;
                end
                else if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    do_ins = 1'b1;
                    status = ST_DONE;
                end
            end
            KIND_DELETE:
            begin
                if (pos_w < cnt_w)
                begin
                    do_del = 1'b1;
                    status = ST_DONE;
                end
            end
            default:
            begin
                status = ST_INVALID;
            end
        endcase
    end

    assign cmd.ins   = fire && do_ins;
    assign cmd.del   = fire && do_del;
    assign cmd.rd    = do_rd;
    assign cmd.value = req.value;
    assign cell_pos  = PW'(eff_pos);

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_d;
        logic [DATA_W-1:0] right_d;
        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_left
            assign left_d = cell_data[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_right
            assign right_d = cell_data[i+1];
        end
        ilid_cell #(
            .PW  (PW),
            .IDX (i)
        ) u_cell (
            .clk     (clk),
            .cmd     (cmd),
            .pos     (cell_pos),
            .left    (left_d),
            .right   (right_d),
            .data    (cell_data[i]),
            .rd_data (cell_rd[i])
        );
    end

    always_comb
    begin
        rd_or = '0;
        for (int j = 0; j < RD_N; j++)
        begin
            rd_or = rd_or | cell_rd[j];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
        begin
            count_next = count_reg + PW'(1);
        end
        else if (cmd.del)
        begin
            count_next = count_reg - PW'(1);
        end
    end

    always_comb
    begin
        rsp_next            = rsp_reg;
        rsp_valid_next      = rsp_valid_reg && rsp_stall;
        if (fire)
        begin
            rsp_valid_next      = 1'b1;
            rsp_next.read_value = do_rd ? rd_or : '1;
            rsp_next.status     = status;
            rsp_next.length     = POS_W'(WW'(count_next));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
